// ===== rtl/bflc_pkg.sv =====
// Shared constants and codes for the bitmap find-first/last and count unit.
`default_nettype none
package bflc_pkg;

    // Bitmap capacity and storage geometry
    localparam int MAX_MAP_BITS = 1024;
    localparam int WORD_BITS    = 8;
    localparam int STORE_WORDS  = (MAX_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int BSEL_W       = $clog2(WORD_BITS);

    // Fixed field widths of the transaction ports
    localparam int OP_W   = 2;
    localparam int POS_W  = 10;
    localparam int SIZE_W = 11;

    // Width of a bit index across the whole store
    localparam int IDX_W = ADDR_W + BSEL_W;
    // Common width for size and index comparisons
    localparam int CMP_W_A = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam int CMP_W_B = ($clog2(MAX_MAP_BITS + 1) > POS_W) ?
                             $clog2(MAX_MAP_BITS + 1) : POS_W;
    localparam int CMP_W   = ((CMP_W_A > CMP_W_B) ? CMP_W_A : CMP_W_B) + 1;
    // Population count width
    localparam int CNT_W   = $clog2(MAX_MAP_BITS + 1);
    localparam int PC_W    = $clog2(WORD_BITS + 1);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TOGGLE = 2'd3
    } t_op;

endpackage
`default_nettype wire

// ===== rtl/bflc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bflc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bitmap_find_first_last_count_unit.sv =====
// Bitmap of up to 1024 bits with bit update, find-first, find-last and population count.
// Each transaction applies a check, set, clear or toggle to one bit position and then
// returns the bit's new value, an error flag for a position at or above the configured
// size, and a fresh scan of the map: whether any bit is set, the lowest and highest set
// positions (0 when none) and the number of set bits. Bits at or above the configured
// size are kept but ignored by the scan. The map lives in a 128 x 8-bit RAM with one
// read port; the scan reads it one word per cycle. A transaction reads the addressed
// word, writes it back, streams all 128 words through the scan and then hands the
// result to the output register. The input is stalled for that whole time, while an
// earlier result may still wait on the output, so the block takes no new transaction
// before the hand-over. A per-word valid bit cleared at reset makes the map read as
// all zeros, so no clearing pass is needed.
`default_nettype none
module bitmap_find_first_last_count_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [bflc_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    // Request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bflc_pkg::OP_W-1:0]    i_operation,
    input  wire logic [bflc_pkg::POS_W-1:0]   i_position,
    // Result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_bit_value,
    output logic                              o_position_error,
    output logic                              o_any_set,
    output logic      [bflc_pkg::POS_W-1:0]   o_first_index,
    output logic      [bflc_pkg::POS_W-1:0]   o_last_index,
    output logic      [bflc_pkg::SIZE_W-1:0]  o_set_count
);

    import bflc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [SIZE_W-1:0]       r_size;
    logic [STORE_WORDS-1:0]  r_word_vld;

    // Captured transaction
    t_op                     r_op;
    logic [POS_W-1:0]        r_pos;
    logic                    r_err;
    logic                    r_bitv;

    // Scan state
    logic [ADDR_W:0]         r_scan_cnt;
    logic                    r_any;
    logic [IDX_W-1:0]        r_first;
    logic [IDX_W-1:0]        r_last;
    logic [CNT_W-1:0]        r_count;

    // RAM side
    logic                    r_rd_vld;
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [WORD_BITS-1:0]    ram_wr_data;
    logic                    ram_rd_en;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [WORD_BITS-1:0]    ram_rd_data;

    // Output register
    logic                    r_out_valid;
    logic                    r_out_bitv;
    logic                    r_out_err;
    logic                    r_out_any;
    logic [POS_W-1:0]        r_out_first;
    logic [POS_W-1:0]        r_out_last;
    logic [SIZE_W-1:0]       r_out_count;

    // Combinational helpers
    logic [CMP_W-1:0]        eff_size;
    logic                    in_accept;
    logic                    in_err;
    logic [ADDR_W-1:0]       pos_word;
    logic [WORD_BITS-1:0]    pos_mask;
    logic [WORD_BITS-1:0]    cur_word;
    logic [WORD_BITS-1:0]    n_word;
    logic [ADDR_W:0]         proc_cnt;
    logic [ADDR_W-1:0]       proc_idx;
    logic [WORD_BITS-1:0]    scan_word;
    logic [BSEL_W-1:0]       scan_lo;
    logic [BSEL_W-1:0]       scan_hi;
    logic [PC_W-1:0]         scan_pc;
    logic                    scan_live;
    logic                    scan_last;
    logic                    out_load;

    bflc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Effective size: configured size capped at the map capacity
    always_comb begin
        if (CMP_W'(r_size) > CMP_W'(MAX_MAP_BITS)) begin
            eff_size = CMP_W'(MAX_MAP_BITS);
        end else begin
            eff_size = CMP_W'(r_size);
        end
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign in_err    = CMP_W'(i_position) >= eff_size;
    assign pos_word  = ADDR_W'(r_pos >> BSEL_W);
    assign pos_mask  = WORD_BITS'(1) << r_pos[BSEL_W-1:0];

    // Modify the addressed word; never-written words read as zero
    assign cur_word = r_rd_vld ? ram_rd_data : '0;
    always_comb begin
        unique case (r_op)
            OP_CHECK:  n_word = cur_word;
            OP_SET:    n_word = cur_word | pos_mask;
            OP_CLEAR:  n_word = cur_word & ~pos_mask;
            OP_TOGGLE: n_word = cur_word ^ pos_mask;
            default:   n_word = cur_word;
        endcase
    end

    assign ram_wr_en   = (r_state == S_MOD) && !r_err && (r_op != OP_CHECK);
    assign ram_wr_addr = pos_word;
    assign ram_wr_data = n_word;

    // Read address: addressed word first, then a linear sweep
    assign ram_rd_en   = (r_state == S_RD) ||
                         ((r_state == S_SCAN) && (r_scan_cnt < (ADDR_W+1)'(STORE_WORDS)));
    assign ram_rd_addr = (r_state == S_RD) ? pos_word : r_scan_cnt[ADDR_W-1:0];

    // Scan the word that arrived from the previous read
    assign scan_live = (r_state == S_SCAN) && (r_scan_cnt != '0);
    assign scan_last = (r_scan_cnt == (ADDR_W+1)'(STORE_WORDS));
    assign proc_cnt  = r_scan_cnt - (ADDR_W+1)'(1);
    assign proc_idx  = proc_cnt[ADDR_W-1:0];

    always_comb begin
        scan_lo = '0;
        scan_hi = '0;
        scan_pc = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            scan_word[b] = cur_word[b] &&
                (CMP_W'({proc_idx, BSEL_W'(b)}) < eff_size);
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (scan_word[b]) begin
                scan_lo = BSEL_W'(b);
            end
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            if (scan_word[b]) begin
                scan_hi = BSEL_W'(b);
            end
            scan_pc = scan_pc + PC_W'(scan_word[b]);
        end
    end

    // Hand the result over once the output register is free or being drained
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // Sequencer, map bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_W'(MAX_MAP_BITS);
            r_word_vld  <= '0;
            r_out_valid <= 1'b0;
            r_scan_cnt  <= '0;
            r_any       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end

            if (ram_rd_en) begin
                r_rd_vld <= r_word_vld[ram_rd_addr];
            end

            // Load a finished result, or drain the output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op    <= t_op'(i_operation);
                        r_pos   <= i_position;
                        r_err   <= in_err;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (ram_wr_en) begin
                        r_word_vld[pos_word] <= 1'b1;
                    end
                    r_bitv     <= !r_err && ((n_word & pos_mask) != '0);
                    r_scan_cnt <= '0;
                    r_any      <= 1'b0;
                    r_first    <= '0;
                    r_last     <= '0;
                    r_count    <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_live && (scan_word != '0)) begin
                        if (!r_any) begin
                            r_first <= {proc_idx, scan_lo};
                        end
                        r_any  <= 1'b1;
                        r_last <= {proc_idx, scan_hi};
                    end
                    if (scan_live) begin
                        r_count <= r_count + CNT_W'(scan_pc);
                    end
                    if (scan_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + (ADDR_W+1)'(1);
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_bitv  <= r_bitv;
                        r_out_err   <= r_err;
                        r_out_any   <= r_any;
                        r_out_first <= POS_W'(CMP_W'(r_first));
                        r_out_last  <= POS_W'(CMP_W'(r_last));
                        r_out_count <= SIZE_W'(CMP_W'(r_count));
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_bit_value      = r_out_bitv;
    assign o_position_error = r_out_err;
    assign o_any_set        = r_out_any;
    assign o_first_index    = r_out_first;
    assign o_last_index     = r_out_last;
    assign o_set_count      = r_out_count;

`ifndef ASSERT_OFF
    // A result's any flag agrees with its count
    a_any_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_any_set == (o_set_count != '0)))
        else $error("any_set disagrees with set_count");

    // Lowest set position never lies above the highest
    a_first_not_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_any_set) |-> (o_first_index <= o_last_index))
        else $error("first_index above last_index");

    // Rejected positions report a clear bit
    a_err_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_position_error) |-> !o_bit_value)
        else $error("bit_value set on a position error");

    // Sweep counter stays within the store
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_cnt <= (ADDR_W+1)'(STORE_WORDS)))
        else $error("scan counter overran the store");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_bitmap_find_first_last_count_unit.sv =====
// Self-checking testbench for the bitmap find-first/last and count unit.
`default_nettype none
module tb_bitmap_find_first_last_count_unit;
    import bflc_pkg::*;

    localparam int      CLK_PERIOD    = 20;
    localparam longint  TIMEOUT_TICKS = 64'd2_000_000 * CLK_PERIOD;

    // Expected content of one result transaction
    typedef struct packed {
        logic              bit_value;
        logic              position_error;
        logic              any_set;
        logic [POS_W-1:0]  first_index;
        logic [POS_W-1:0]  last_index;
        logic [SIZE_W-1:0] set_count;
    } map_reply_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [SIZE_W-1:0]   i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_operation;
    logic [POS_W-1:0]    i_position;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_bit_value;
    logic                o_position_error;
    logic                o_any_set;
    logic [POS_W-1:0]    o_first_index;
    logic [POS_W-1:0]    o_last_index;
    logic [SIZE_W-1:0]   o_set_count;

    // Shadow copy of the bitmap and the size register
    logic [MAX_MAP_BITS-1:0] shadow_map;
    logic [SIZE_W-1:0]       shadow_size;

    map_reply_t  pending_replies[$];
    int          mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_off_left  = 0;

    bitmap_find_first_last_count_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bit_value      (o_bit_value),
        .o_position_error (o_position_error),
        .o_any_set        (o_any_set),
        .o_first_index    (o_first_index),
        .o_last_index     (o_last_index),
        .o_set_count      (o_set_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Number of bits the scan covers under the current size
    function automatic int unsigned map_limit();
        return (shadow_size > MAX_MAP_BITS) ? MAX_MAP_BITS : shadow_size;
    endfunction

    // Apply one operation to the shadow map and scan it
    function automatic map_reply_t apply_and_scan(t_op op, logic [POS_W-1:0] pos);
        map_reply_t  r;
        int unsigned lim;
        r   = '0;
        lim = map_limit();
        if (pos >= lim) begin
            r.position_error = 1'b1;
        end else begin
            case (op)
                OP_SET:    shadow_map[pos] = 1'b1;
                OP_CLEAR:  shadow_map[pos] = 1'b0;
                OP_TOGGLE: shadow_map[pos] = ~shadow_map[pos];
                default:   ;
            endcase
            r.bit_value = shadow_map[pos];
        end
        for (int p = 0; p < lim; p++) begin
            if (shadow_map[p]) begin
                if (!r.any_set) begin
                    r.first_index = POS_W'(p);
                end
                r.any_set    = 1'b1;
                r.last_index = POS_W'(p);
                r.set_count  = r.set_count + 1'b1;
            end
        end
        return r;
    endfunction

    // Print one line per mismatch and count every one
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Offer one request transaction; return at the falling edge after acceptance
    task automatic send_request(t_op op, logic [POS_W-1:0] pos);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_replies.push_back(apply_and_scan(op, pos));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        wait_for_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_size    = value;
    endtask

    // Change idling between edges so the stall process sees a settled value
    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge i_clk);
    endtask

    // Mostly legal positions, some at the size boundary, some anywhere
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned lim;
        int unsigned roll;
        int          p;
        lim  = map_limit();
        roll = $urandom_range(99);
        if (lim != 0 && roll < 70) begin
            p = $urandom_range(lim - 1);
        end else if (roll < 82) begin
            p = int'(lim) + int'($urandom_range(2)) - 1;
            if (p < 0) begin
                p = 0;
            end
        end else begin
            p = $urandom_range((1 << POS_W) - 1);
        end
        return POS_W'(p);
    endfunction

    task automatic run_random_items(int count);
        for (int n = 0; n < count; n++) begin
            send_request(t_op'($urandom_range(3)), pick_position());
        end
    endtask

    // Receiver stall: a long hold-off when requested, otherwise random
    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            i_out_stall  <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Check each accepted result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        map_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result with no expectation waiting");
            end else begin
                want = pending_replies.pop_front();
                compare_field("bit_value", o_bit_value, want.bit_value);
                compare_field("position_error", o_position_error, want.position_error);
                compare_field("any_set", o_any_set, want.any_set);
                compare_field("first_index", o_first_index, want.first_index);
                compare_field("last_index", o_last_index, want.last_index);
                compare_field("set_count", o_set_count, want.set_count);
            end
        end
    end

    // Empty map straight after reset
    task automatic test_empty_map();
        send_request(OP_CHECK, '0);
        send_request(OP_CHECK, '1);
    endtask

    // Each operation at the ends of the map and across a word boundary
    task automatic test_single_ops();
        send_request(OP_SET, '0);
        send_request(OP_SET, '1);
        send_request(OP_TOGGLE, 10'd512);
        send_request(OP_CHECK, 10'd512);
        send_request(OP_CLEAR, '0);
        send_request(OP_TOGGLE, 10'd512);
        send_request(OP_CLEAR, '1);
        send_request(OP_SET, 10'd7);
        send_request(OP_SET, 10'd8);
        send_request(OP_CHECK, 10'd8);
    endtask

    // Out-of-range positions, hidden bits and size register extremes
    task automatic test_size_limits();
        send_request(OP_SET, 10'd900);
        write_size(11'd100);
        send_request(OP_CHECK, 10'd50);
        send_request(OP_SET, 10'd900);
        send_request(OP_SET, 10'd100);
        send_request(OP_TOGGLE, 10'd99);
        write_size('0);
        send_request(OP_CHECK, '0);
        send_request(OP_SET, '0);
        write_size(11'd1);
        send_request(OP_SET, '0);
        send_request(OP_SET, 10'd1);
        write_size('1);
        send_request(OP_CHECK, 10'd900);
        send_request(OP_SET, '1);
    endtask

    task automatic test_random_no_idle();
        write_size(11'd1024);
        set_idling(0, 0);
        run_random_items(300);
    endtask

    task automatic test_random_sender_idle();
        write_size(11'd64);
        set_idling(55, 0);
        run_random_items(300);
    endtask

    task automatic test_random_receiver_stall();
        write_size(11'd2047);
        set_idling(0, 55);
        run_random_items(300);
    endtask

    task automatic test_random_both_idle();
        write_size(SIZE_W'($urandom_range(1, 1023)));
        set_idling(28, 28);
        run_random_items(250);
    endtask

    // Hold the result channel off so the block fills and stalls its input
    task automatic test_output_hold_off();
        write_size(11'd13);
        set_idling(0, 0);
        @(posedge i_clk);
        hold_off_left = 800;
        @(negedge i_clk);
        run_random_items(100);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_operation   = '0;
        i_position    = '0;
        i_out_stall   = 1'b0;
        shadow_map    = '0;
        shadow_size   = 11'd1024;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_map();
        test_single_ops();
        test_size_limits();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_output_hold_off();

        // Let any stray result show before the verdict
        wait_for_idle();
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("bitmap_find_first_last_count_unit regression: pass");
        end else begin
            $display("bitmap_find_first_last_count_unit regression: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_TICKS);
        $display("bitmap_find_first_last_count_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
